### sv/s2cd_pkg.sv
// Package for the seconds-to-calendar-date converter.
// Holds the time constants, the controller and phase codes, the command and status
// structs, and the month length function. It depends on nothing.
`default_nettype none

package s2cd_pkg;

    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_DAY  = 86400;

    localparam logic [31:0] YEAR_SECS      = 32'(365 * SECS_PER_DAY);
    localparam logic [31:0] LEAP_YEAR_SECS = 32'(366 * SECS_PER_DAY);

    localparam logic [21:0] MONTH31_SECS = 22'(31 * SECS_PER_DAY);
    localparam logic [21:0] MONTH30_SECS = 22'(30 * SECS_PER_DAY);
    localparam logic [21:0] FEB29_SECS   = 22'(29 * SECS_PER_DAY);
    localparam logic [21:0] FEB28_SECS   = 22'(28 * SECS_PER_DAY);

    localparam logic [11:0] EPOCH_RESET = 12'd2010;
    localparam logic [11:0] YEAR_MAX    = 12'hFFF;
    localparam logic [11:0] CYCLE_400   = 12'd400;
    localparam logic [11:0] CYCLE_LAST  = 12'd399;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_MOD,
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MIN
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   step;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic ge;
        logic month_last;
    } t_status;

    function automatic logic [21:0] month_span(input logic [3:0] month, input logic leap);
        logic [21:0] span;
        case (month) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: span = MONTH30_SECS;
            MONTH_FEB: span = leap ? FEB29_SECS : FEB28_SECS;
            default:   span = MONTH31_SECS;
        endcase
        return span;
    endfunction

endpackage

`default_nettype wire

### sv/s2cd_ctrl.sv
// Controller state machine of the seconds-to-calendar-date converter.
// Sequences the datapath through its subtract phases; uses s2cd_pkg.
`default_nettype none

module s2cd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire s2cd_pkg::t_status i_status,
    output s2cd_pkg::t_cmd        o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    s2cd_pkg::t_state r_state;
    s2cd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s2cd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            s2cd_pkg::ST_IDLE: begin
                if (i_start) n_state = s2cd_pkg::ST_MOD;
            end
            s2cd_pkg::ST_MOD: begin
                if (!i_status.ge) n_state = s2cd_pkg::ST_YEAR;
            end
            s2cd_pkg::ST_YEAR: begin
                if (!i_status.ge) n_state = s2cd_pkg::ST_MONTH;
            end
            s2cd_pkg::ST_MONTH: begin
                if (!i_status.ge || i_status.month_last) n_state = s2cd_pkg::ST_DAY;
            end
            s2cd_pkg::ST_DAY: begin
                if (!i_status.ge) n_state = s2cd_pkg::ST_HOUR;
            end
            s2cd_pkg::ST_HOUR: begin
                if (!i_status.ge) n_state = s2cd_pkg::ST_MIN;
            end
            s2cd_pkg::ST_MIN: begin
                if (!i_status.ge) n_state = s2cd_pkg::ST_DONE;
            end
            s2cd_pkg::ST_DONE: begin
                n_state = s2cd_pkg::ST_IDLE;
            end
            default: begin
                n_state = s2cd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load  = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.phase = s2cd_pkg::PH_MOD;
        o_busy      = 1'b1;
        o_done      = 1'b0;
        unique case (r_state)
            s2cd_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            s2cd_pkg::ST_MOD: begin
                o_cmd.phase = s2cd_pkg::PH_MOD;
                o_cmd.step  = i_status.ge;
            end
            s2cd_pkg::ST_YEAR: begin
                o_cmd.phase = s2cd_pkg::PH_YEAR;
                o_cmd.step  = i_status.ge;
            end
            s2cd_pkg::ST_MONTH: begin
                o_cmd.phase = s2cd_pkg::PH_MONTH;
                o_cmd.step  = i_status.ge && !i_status.month_last;
            end
            s2cd_pkg::ST_DAY: begin
                o_cmd.phase = s2cd_pkg::PH_DAY;
                o_cmd.step  = i_status.ge;
            end
            s2cd_pkg::ST_HOUR: begin
                o_cmd.phase = s2cd_pkg::PH_HOUR;
                o_cmd.step  = i_status.ge;
            end
            s2cd_pkg::ST_MIN: begin
                o_cmd.phase = s2cd_pkg::PH_MIN;
                o_cmd.step  = i_status.ge;
            end
            s2cd_pkg::ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/s2cd_datapath.sv
// Datapath of the seconds-to-calendar-date converter: the remaining-seconds register,
// the date counters and one shared compare-and-subtract unit. Uses s2cd_pkg.
`default_nettype none

module s2cd_datapath (
    input  wire logic             i_clk,
    input  wire s2cd_pkg::t_cmd   i_cmd,
    input  wire logic [31:0]      i_elapsed_seconds,
    input  wire logic [11:0]      i_epoch_year,
    output s2cd_pkg::t_status     o_status,
    output logic [11:0]           o_year,
    output logic [3:0]            o_month,
    output logic [4:0]            o_day,
    output logic [4:0]            o_hour,
    output logic [5:0]            o_minute,
    output logic [5:0]            o_second
);

    logic [31:0] r_rest;
    logic [11:0] r_year;
    logic [11:0] r_y400;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;

    logic        leap;
    logic [31:0] span;

    // The year modulo 400 is tracked beside the year so the leap rule needs no divider.
    assign leap = (r_y400[1:0] == 2'b00) && (r_y400 != 12'd100) && (r_y400 != 12'd200)
                  && (r_y400 != 12'd300);

    always_comb begin
        span = '0;
        case (i_cmd.phase)
            s2cd_pkg::PH_YEAR:  span = leap ? s2cd_pkg::LEAP_YEAR_SECS : s2cd_pkg::YEAR_SECS;
            s2cd_pkg::PH_MONTH: span = {10'd0, s2cd_pkg::month_span(r_month, leap)};
            s2cd_pkg::PH_DAY:   span = 32'(s2cd_pkg::SECS_PER_DAY);
            s2cd_pkg::PH_HOUR:  span = 32'(s2cd_pkg::SECS_PER_HOUR);
            s2cd_pkg::PH_MIN:   span = 32'(s2cd_pkg::SECS_PER_MIN);
            default:            span = '0;
        endcase
    end

    always_comb begin
        if (i_cmd.phase == s2cd_pkg::PH_MOD) begin
            o_status.ge = (r_y400 >= s2cd_pkg::CYCLE_400);
        end else begin
            o_status.ge = (r_rest >= span);
        end
        o_status.month_last = (r_month == s2cd_pkg::MONTH_DEC);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest   <= i_elapsed_seconds;
            r_year   <= i_epoch_year;
            r_y400   <= i_epoch_year;
            r_month  <= s2cd_pkg::MONTH_JAN;
            r_day    <= 5'd1;
            r_hour   <= '0;
            r_minute <= '0;
        end else if (i_cmd.step) begin
            case (i_cmd.phase)
                s2cd_pkg::PH_MOD: begin
                    r_y400 <= r_y400 - s2cd_pkg::CYCLE_400;
                end
                s2cd_pkg::PH_YEAR: begin
                    r_rest <= r_rest - span;
                    r_year <= r_year + 12'd1;
                    if (r_year == s2cd_pkg::YEAR_MAX || r_y400 == s2cd_pkg::CYCLE_LAST) begin
                        r_y400 <= '0;
                    end else begin
                        r_y400 <= r_y400 + 12'd1;
                    end
                end
                s2cd_pkg::PH_MONTH: begin
                    r_rest  <= r_rest - span;
                    r_month <= r_month + 4'd1;
                end
                s2cd_pkg::PH_DAY: begin
                    r_rest <= r_rest - span;
                    r_day  <= r_day + 5'd1;
                end
                s2cd_pkg::PH_HOUR: begin
                    r_rest <= r_rest - span;
                    r_hour <= r_hour + 5'd1;
                end
                s2cd_pkg::PH_MIN: begin
                    r_rest   <= r_rest - span;
                    r_minute <= r_minute + 6'd1;
                end
                default: begin
                    r_rest <= r_rest;
                end
            endcase
        end
    end

    assign o_year   = r_year;
    assign o_month  = r_month;
    assign o_day    = r_day;
    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_rest[5:0];

endmodule

`default_nettype wire

### sv/seconds_to_calendar_date.sv
// Top level of the seconds-to-calendar-date converter: epoch register, controller
// and datapath. Uses s2cd_pkg, s2cd_ctrl and s2cd_datapath.
//
// An item is taken when i_start is high and o_busy is low; its date appears for
// one cycle with o_done, and the receiver cannot stall it. One compare-and-subtract
// unit strips the epoch modulo 400, then years, months, days, hours and minutes one
// step per cycle, and takes no new item until its date has been strobed.
// The user writes the epoch register with i_cfg_we only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module seconds_to_calendar_date (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_elapsed_seconds,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_data,
    output logic             o_done,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);

    logic [11:0]       r_epoch_year;
    s2cd_pkg::t_cmd    cmd;
    s2cd_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_year <= s2cd_pkg::EPOCH_RESET;
        end else if (i_cfg_we) begin
            r_epoch_year <= i_cfg_data;
        end
    end

    s2cd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    s2cd_datapath u_datapath (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_epoch_year      (r_epoch_year),
        .o_status          (status),
        .o_year            (o_year),
        .o_month           (o_month),
        .o_day             (o_day),
        .o_hour            (o_hour),
        .o_minute          (o_minute),
        .o_second          (o_second)
    );

endmodule

`default_nettype wire

### tb/s2cd_date_check.sv
// Checker for the seconds-to-calendar-date converter: watches the item, result
// and configuration ports, predicts each date and compares it field by field.
// Depends on s2cd_pkg for the month codes and time constants.

module s2cd_date_check
    import s2cd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [31:0] i_elapsed_seconds,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        i_done,
    input  wire logic [11:0] i_year,
    input  wire logic [3:0]  i_month,
    input  wire logic [4:0]  i_day,
    input  wire logic [4:0]  i_hour,
    input  wire logic [5:0]  i_minute,
    input  wire logic [5:0]  i_second,
    output int               o_mismatches,
    output int               o_outstanding,
    output int               o_converted
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_date_t;

    typedef struct packed {
        logic [31:0] secs;
        logic [11:0] epoch;
        cal_date_t   date;
    } awaited_date_t;

    logic [11:0]   epoch_year;
    awaited_date_t awaited_dates[$];
    awaited_date_t oldest;
    awaited_date_t fresh;

    function automatic bit leap_year(input logic [11:0] y);
        int unsigned yi;
        yi = y;
        return ((yi % 4) == 0 && (yi % 100) != 0) || ((yi % 400) == 0);
    endfunction

    function automatic longint unsigned month_secs(input logic [11:0] y,
                                                   input logic [3:0] m);
        longint unsigned days;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            days = 30;
        end else if (m == MONTH_FEB) begin
            days = leap_year(y) ? 29 : 28;
        end else begin
            days = 31;
        end
        return days * SECS_PER_DAY;
    endfunction

    function automatic cal_date_t calendar_date(input logic [11:0] epoch,
                                                input logic [31:0] secs);
        longint unsigned rest;
        longint unsigned span;
        cal_date_t       d;
        rest = secs;
        d.year = epoch;
        d.month = MONTH_JAN;
        span = (leap_year(d.year) ? 366 : 365) * SECS_PER_DAY;
        while (rest >= span) begin
            rest = rest - span;
            d.year = d.year + 12'd1;
            span = (leap_year(d.year) ? 366 : 365) * SECS_PER_DAY;
        end
        while (d.month < MONTH_DEC && rest >= month_secs(d.year, d.month)) begin
            rest = rest - month_secs(d.year, d.month);
            d.month = d.month + 4'd1;
        end
        d.day = 5'(rest / SECS_PER_DAY + 1);
        rest = rest % SECS_PER_DAY;
        d.hour = 5'(rest / SECS_PER_HOUR);
        rest = rest % SECS_PER_HOUR;
        d.minute = 6'(rest / SECS_PER_MIN);
        d.second = 6'(rest % SECS_PER_MIN);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_mismatches < 40) begin
            $display("mismatch %s: got %0d, expected %0d (seconds %0d, epoch %0d)",
                     what, got, want, oldest.secs, oldest.epoch);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            epoch_year = EPOCH_RESET;
            awaited_dates.delete();
        end else begin
            if (i_done) begin
                if (awaited_dates.size() == 0) begin
                    oldest = '0;
                    report_mismatch("on result with no item pending, year", i_year, 0);
                end else begin
                    oldest = awaited_dates.pop_front();
                    o_converted++;
                    if (i_year !== oldest.date.year)
                        report_mismatch("year", i_year, oldest.date.year);
                    if (i_month !== oldest.date.month)
                        report_mismatch("month", i_month, oldest.date.month);
                    if (i_day !== oldest.date.day)
                        report_mismatch("day", i_day, oldest.date.day);
                    if (i_hour !== oldest.date.hour)
                        report_mismatch("hour", i_hour, oldest.date.hour);
                    if (i_minute !== oldest.date.minute)
                        report_mismatch("minute", i_minute, oldest.date.minute);
                    if (i_second !== oldest.date.second)
                        report_mismatch("second", i_second, oldest.date.second);
                end
            end
            if (i_start && !i_busy) begin
                fresh.secs = i_elapsed_seconds;
                fresh.epoch = epoch_year;
                fresh.date = calendar_date(epoch_year, i_elapsed_seconds);
                awaited_dates.push_back(fresh);
            end
            if (i_cfg_we) begin
                epoch_year = i_cfg_data;
            end
        end
        o_outstanding = awaited_dates.size();
    end

endmodule

### tb/tb_seconds_to_calendar_date.sv
// Top of the seconds-to-calendar-date testbench: clock, reset, epoch settings and
// bursts of timestamps, then the verdict. Uses the converter, s2cd_pkg and the
// date checker in s2cd_date_check.

module tb_seconds_to_calendar_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [31:0] i_elapsed_seconds = '0;
    logic        i_cfg_we = 1'b0;
    logic [11:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_done;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    int mismatches;
    int outstanding;
    int converted;
    int items_sent;
    int epochs_used;

    localparam int EPOCH_COUNT = 9;
    localparam logic [11:0] EPOCH_PLAN [EPOCH_COUNT] = '{
        12'd2000, 12'd2099, 12'd0, 12'd4095, 12'd2096, 12'd2010, 12'd1999,
        12'd2055, 12'd3999
    };

    seconds_to_calendar_date dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_year            (o_year),
        .o_month           (o_month),
        .o_day             (o_day),
        .o_hour            (o_hour),
        .o_minute          (o_minute),
        .o_second          (o_second)
    );

    s2cd_date_check date_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_done            (o_done),
        .i_year            (o_year),
        .i_month           (o_month),
        .i_day             (o_day),
        .i_hour            (o_hour),
        .i_minute          (o_minute),
        .i_second          (o_second),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_converted       (converted)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Holds start high until the item is taken; start stays high for the next item.
    task automatic send_item(input logic [31:0] secs);
        i_start <= 1'b1;
        i_elapsed_seconds <= secs;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_epoch(input logic [11:0] epoch);
        i_cfg_we <= 1'b1;
        i_cfg_data <= epoch;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_data <= 12'($urandom);
        @(posedge i_clk);
        epochs_used++;
    endtask

    function automatic logic [31:0] pick_seconds();
        logic [31:0] day_num;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 3 * 366 * s2cd_pkg::SECS_PER_DAY);
            6, 7, 8: begin
                day_num = $urandom_range(0, 49710);
                return day_num * s2cd_pkg::SECS_PER_DAY - 1 + $urandom_range(0, 2);
            end
            default:    return $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    task automatic random_bursts(input int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                if (sent < count) begin
                    send_item(pick_seconds());
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 300));
            end
        end
        i_start <= 1'b0;
    endtask

    initial begin
        logic [31:0] directed[$];
        directed = '{
            32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'(31 * s2cd_pkg::SECS_PER_DAY - 1), 32'(31 * s2cd_pkg::SECS_PER_DAY),
            32'(59 * s2cd_pkg::SECS_PER_DAY - 1), 32'(59 * s2cd_pkg::SECS_PER_DAY),
            32'(365 * s2cd_pkg::SECS_PER_DAY - 1), 32'(365 * s2cd_pkg::SECS_PER_DAY),
            32'((730 + 59) * s2cd_pkg::SECS_PER_DAY),
            32'((730 + 60) * s2cd_pkg::SECS_PER_DAY - 1),
            32'((730 + 366) * s2cd_pkg::SECS_PER_DAY - 1), 32'hFFFF_FFFF, 32'h8000_0000,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // The reset epoch is used first, then every setting is written.
        foreach (directed[k]) send_item(directed[k]);
        random_bursts(40);
        wait_idle();

        foreach (EPOCH_PLAN[p]) begin
            write_epoch(EPOCH_PLAN[p]);
            send_item(32'd0);
            send_item(32'hFFFF_FFFF);
            random_bursts(60);
            // The sender holds off once mid-phase until every result is back.
            wait_idle();
            random_bursts(47);
            wait_idle();
        end

        write_epoch(12'($urandom_range(2000, 2099)));
        random_bursts(60);
        wait_idle();
        repeat (300) @(posedge i_clk);

        $display("Converted %0d of %0d timestamps under %0d epoch settings,",
                 converted, items_sent, epochs_used + 1);
        $display("including epochs 0 and 4095 and counts from zero to all ones.");
        if (mismatches == 0 && outstanding == 0 && converted == items_sent) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
